/* design/blpg_pkg.sv */
// ----------------------------------------------------------------------------
// blpg_pkg
// Shared constants and codes for the line pixel generator.
// ----------------------------------------------------------------------------
package blpg_pkg;

    // default coordinate width and fixed color width
    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_W        = 16;

    // request mode codes
    typedef enum logic {
        MODE_START   = 1'b0,
        MODE_ADVANCE = 1'b1
    } mode_t;

    // result kind codes
    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_FILL  = 1'b1
    } kind_t;

endpackage

/* design/bresenham_line_pixel_generator.sv */
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle unless out_stall holds the result; an advance yields a pixel only mid-line.
// The line state update is a single add/compare step between registers.
// Reset (async, active low) clears the busy flag, swap_axes and both valids.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator
    import blpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    // request channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         mode,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic        [COLOR_W-1:0]    pen_color,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         kind,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic        [COORD_BITS:0]   out_width,
    output logic        [COORD_BITS:0]   out_height,
    output logic        [COLOR_W-1:0]    out_color,
    output logic                         last
);

    logic                         req_valid;
    logic                         req_take;
    logic                         req_mode;
    logic signed [COORD_BITS-1:0] req_x1;
    logic signed [COORD_BITS-1:0] req_y1;
    logic signed [COORD_BITS-1:0] req_x2;
    logic signed [COORD_BITS-1:0] req_y2;
    logic        [COLOR_W-1:0]    req_color;

    // input register
    blpg_in_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .x_start   (x_start),
        .y_start   (y_start),
        .x_end     (x_end),
        .y_end     (y_end),
        .pen_color (pen_color),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req_mode  (req_mode),
        .req_x1    (req_x1),
        .req_y1    (req_y1),
        .req_x2    (req_x2),
        .req_y2    (req_y2),
        .req_color (req_color)
    );

    // line state, step logic and result register
    blpg_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_take    (req_take),
        .req_mode    (req_mode),
        .req_x1      (req_x1),
        .req_y1      (req_y1),
        .req_x2      (req_x2),
        .req_y2      (req_y2),
        .req_color   (req_color),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_width   (out_width),
        .out_height  (out_height),
        .out_color   (out_color),
        .last        (last)
    );

endmodule

/* design/blpg_in_stage.sv */
// ----------------------------------------------------------------------------
// blpg_in_stage
// Input register for line requests; refills when empty or when the step stage takes.
// ----------------------------------------------------------------------------
module blpg_in_stage
    import blpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel from outside
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         mode,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic        [COLOR_W-1:0]    pen_color,
    // registered request toward the step stage
    output logic                         req_valid,
    input  logic                         req_take,
    output logic                         req_mode,
    output logic signed [COORD_BITS-1:0] req_x1,
    output logic signed [COORD_BITS-1:0] req_y1,
    output logic signed [COORD_BITS-1:0] req_x2,
    output logic signed [COORD_BITS-1:0] req_y2,
    output logic        [COLOR_W-1:0]    req_color
);

    logic                         valid_reg;
    logic                         valid_next;
    logic                         load;
    logic                         mode_reg;
    logic signed [COORD_BITS-1:0] x1_reg;
    logic signed [COORD_BITS-1:0] y1_reg;
    logic signed [COORD_BITS-1:0] x2_reg;
    logic signed [COORD_BITS-1:0] y2_reg;
    logic        [COLOR_W-1:0]    color_reg;

    // register is free when empty or being consumed this cycle
    assign load     = !valid_reg || req_take;
    assign in_stall = !load;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = in_valid;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            mode_reg  <= mode;
            x1_reg    <= x_start;
            y1_reg    <= y_start;
            x2_reg    <= x_end;
            y2_reg    <= y_end;
            color_reg <= pen_color;
        end
    end

    assign req_valid = valid_reg;
    assign req_mode  = mode_reg;
    assign req_x1    = x1_reg;
    assign req_y1    = y1_reg;
    assign req_x2    = x2_reg;
    assign req_y2    = y2_reg;
    assign req_color = color_reg;

endmodule

/* design/blpg_step.sv */
// ----------------------------------------------------------------------------
// blpg_step
// Line state, one Bresenham step or line setup per cycle unless out_stall holds the result, result register.
// ----------------------------------------------------------------------------
module blpg_step
    import blpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    // registered request
    input  logic                         req_valid,
    output logic                         req_take,
    input  logic                         req_mode,
    input  logic signed [COORD_BITS-1:0] req_x1,
    input  logic signed [COORD_BITS-1:0] req_y1,
    input  logic signed [COORD_BITS-1:0] req_x2,
    input  logic signed [COORD_BITS-1:0] req_y2,
    input  logic        [COLOR_W-1:0]    req_color,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         kind,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic        [COORD_BITS:0]   out_width,
    output logic        [COORD_BITS:0]   out_height,
    output logic        [COLOR_W-1:0]    out_color,
    output logic                         last
);

    localparam int CB    = COORD_BITS;
    localparam int ERR_W = COORD_BITS + 2;
    localparam int E2_W  = COORD_BITS + 3;

    // configuration register
    logic swap_axes_reg;

    // line state
    logic                  busy_reg,   busy_next;
    logic signed [CB-1:0]  cur_x_reg,  cur_x_next;
    logic signed [CB-1:0]  cur_y_reg,  cur_y_next;
    logic signed [CB-1:0]  goal_x_reg, goal_x_next;
    logic signed [CB-1:0]  goal_y_reg, goal_y_next;
    logic        [CB-1:0]  span_x_reg, span_x_next;
    logic        [CB-1:0]  span_y_reg, span_y_next;
    logic                  neg_x_reg,  neg_x_next;
    logic                  neg_y_reg,  neg_y_next;
    logic signed [ERR_W-1:0] err_reg,  err_next;
    logic        [COLOR_W-1:0] color_reg, color_next;

    // result register
    logic                  res_valid_reg, res_valid_next;
    logic                  res_kind_reg;
    logic signed [CB-1:0]  res_x_reg;
    logic signed [CB-1:0]  res_y_reg;
    logic        [CB:0]    res_w_reg;
    logic        [CB:0]    res_h_reg;
    logic        [COLOR_W-1:0] res_color_reg;
    logic                  res_last_reg;

    // combinational result before axis swap
    logic                  r_kind;
    logic signed [CB-1:0]  r_x;
    logic signed [CB-1:0]  r_y;
    logic        [CB:0]    r_w;
    logic        [CB:0]    r_h;
    logic        [COLOR_W-1:0] r_color;
    logic                  r_last;

    // setup arithmetic
    logic                  process;
    logic signed [CB:0]    dx;
    logic signed [CB:0]    dy;
    logic        [CB-1:0]  abs_dx;
    logic        [CB-1:0]  abs_dy;
    logic        [CB:0]    len_x;
    logic        [CB:0]    len_y;

    // step arithmetic
    logic signed [E2_W-1:0] e2;
    logic signed [E2_W-1:0] span_x_e;
    logic signed [E2_W-1:0] neg_span_y_e;
    logic                   step_x;
    logic                   step_y;
    logic signed [CB-1:0]   nx;
    logic signed [CB-1:0]   ny;

    assign req_take = !res_valid_reg || !out_stall;
    assign process  = req_valid && req_take;

    // endpoint differences and lengths
    assign dx     = $signed({req_x2[CB-1], req_x2}) - $signed({req_x1[CB-1], req_x1});
    assign dy     = $signed({req_y2[CB-1], req_y2}) - $signed({req_y1[CB-1], req_y1});
    assign abs_dx = dx[CB] ? CB'(-dx) : dx[CB-1:0];
    assign abs_dy = dy[CB] ? CB'(-dy) : dy[CB-1:0];
    assign len_x  = {1'b0, abs_dx} + (CB+1)'(1);
    assign len_y  = {1'b0, abs_dy} + (CB+1)'(1);

    // Bresenham decision on the current error term
    assign e2           = {err_reg, 1'b0};
    assign span_x_e     = $signed({3'b000, span_x_reg});
    assign neg_span_y_e = -$signed({3'b000, span_y_reg});
    assign step_x       = e2 > neg_span_y_e;
    assign step_y       = e2 < span_x_e;
    assign nx = step_x ? (neg_x_reg ? cur_x_reg - CB'(1) : cur_x_reg + CB'(1)) : cur_x_reg;
    assign ny = step_y ? (neg_y_reg ? cur_y_reg - CB'(1) : cur_y_reg + CB'(1)) : cur_y_reg;

    // next state and result
    always_comb
    begin
        busy_next      = busy_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        goal_x_next    = goal_x_reg;
        goal_y_next    = goal_y_reg;
        span_x_next    = span_x_reg;
        span_y_next    = span_y_reg;
        neg_x_next     = neg_x_reg;
        neg_y_next     = neg_y_reg;
        err_next       = err_reg;
        color_next     = color_reg;
        res_valid_next = res_valid_reg && out_stall;
        r_kind         = KIND_PIXEL;
        r_x            = cur_x_reg;
        r_y            = cur_y_reg;
        r_w            = (CB+1)'(1);
        r_h            = (CB+1)'(1);
        r_color        = color_reg;
        r_last         = 1'b0;

        if (process)
        begin
            if (req_mode == MODE_START)
            begin
                color_next     = req_color;
                r_color        = req_color;
                res_valid_next = 1'b1;
                if (req_x1 == req_x2)
                begin
                    // vertical line or single point: one column fill
                    busy_next = 1'b0;
                    r_kind    = KIND_FILL;
                    r_x       = req_x1;
                    r_y       = dy[CB] ? req_y2 : req_y1;
                    r_h       = len_y;
                    r_last    = 1'b1;
                end
                else if (req_y1 == req_y2)
                begin
                    // horizontal line: one row fill
                    busy_next = 1'b0;
                    r_kind    = KIND_FILL;
                    r_x       = dx[CB] ? req_x2 : req_x1;
                    r_y       = req_y1;
                    r_w       = len_x;
                    r_last    = 1'b1;
                end
                else
                begin
                    // sloped line: load walk state, emit end pixel
                    busy_next   = 1'b1;
                    cur_x_next  = req_x1;
                    cur_y_next  = req_y1;
                    goal_x_next = req_x2;
                    goal_y_next = req_y2;
                    span_x_next = abs_dx;
                    span_y_next = abs_dy;
                    neg_x_next  = !(req_x1 < req_x2);
                    neg_y_next  = !(req_y1 < req_y2);
                    err_next    = $signed({2'b00, abs_dx}) - $signed({2'b00, abs_dy});
                    r_x         = req_x2;
                    r_y         = req_y2;
                end
            end
            else if (busy_reg)
            begin
                // one walk step; emit the pixel before the move
                cur_x_next     = nx;
                cur_y_next     = ny;
                err_next       = err_reg
                                 - (step_x ? $signed({2'b00, span_y_reg}) : ERR_W'(0))
                                 + (step_y ? $signed({2'b00, span_x_reg}) : ERR_W'(0));
                res_valid_next = 1'b1;
                if ((nx == goal_x_reg) && (ny == goal_y_reg))
                begin
                    busy_next = 1'b0;
                    r_last    = 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_axes_reg <= 1'b0;
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                swap_axes_reg <= cfg_wr_data;
            end
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // walk state
    always_ff @(posedge clk)
    begin
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        goal_x_reg <= goal_x_next;
        goal_y_reg <= goal_y_next;
        span_x_reg <= span_x_next;
        span_y_reg <= span_y_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        err_reg    <= err_next;
        color_reg  <= color_next;
    end

    // result payload, axis swap applied on load
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            res_kind_reg  <= r_kind;
            res_x_reg     <= swap_axes_reg ? r_y : r_x;
            res_y_reg     <= swap_axes_reg ? r_x : r_y;
            res_w_reg     <= swap_axes_reg ? r_h : r_w;
            res_h_reg     <= swap_axes_reg ? r_w : r_h;
            res_color_reg <= r_color;
            res_last_reg  <= r_last;
        end
    end

    assign out_valid  = res_valid_reg;
    assign kind       = res_kind_reg;
    assign out_x      = res_x_reg;
    assign out_y      = res_y_reg;
    assign out_width  = res_w_reg;
    assign out_height = res_h_reg;
    assign out_color  = res_color_reg;
    assign last       = res_last_reg;

endmodule
